// File: design/ots_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_pkg
// Shared types, codes and constants of the overlap-add time stretch block.
// ----------------------------------------------------------------------------
package ots_pkg;

  localparam int COS_DEPTH = 256;
  localparam int COS_LOG   = $clog2(COS_DEPTH);
  localparam int HOP_MIN   = 64;
  localparam int HOP_MAX   = 4096;
  localparam int TEMPO_MIN = 3277;
  localparam int TEMPO_MAX = 1048576;
  localparam int WIN_DEPTH = 2 * HOP_MAX;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int HOP_W     = 13;
  localparam int WGT_W     = 16;
  localparam int DIV_W     = 40;
  localparam int DVS_W     = 18;
  localparam int CFG_W     = 21;

  typedef enum logic [1:0] {
    CMD_LOAD_SAMPLE   = 2'd0,
    CMD_LOAD_POSITION = 2'd1,
    CMD_RUN           = 2'd2,
    CMD_READ          = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HOP        = 3'd0,
    REG_CHANNELS   = 3'd1,
    REG_IN_LEN     = 3'd2,
    REG_OUT_LEN    = 3'd3,
    REG_TEMPO_MODE = 3'd4,
    REG_TEMPO      = 3'd5
  } reg_t;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_EMPTY  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [16:0] cos_rom_t [0:COS_DEPTH];

  // Quarter-wave cosine in Q.15, series evaluated at elaboration
  function automatic logic [16:0] cos_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (64'd1686629713 * 64'(k)) / 64'(COS_DEPTH);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd16384) >> 15;
    return (r > 64'd32768) ? 17'd32768 : 17'(r);
  endfunction

  function automatic cos_rom_t cos_rom_build();
    cos_rom_t rom;
    for (int k = 0; k <= COS_DEPTH; k++) rom[k] = cos_entry(k);
    return rom;
  endfunction

endpackage

// File: design/ots_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ots_div (
  input  logic              clk,
  input  logic              rst,
  input  ots_pkg::div_req_t req,
  output ots_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ots_pkg::DIV_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic                      done;
  logic [ots_pkg::DVS_W-1:0] rem;
  logic [ots_pkg::DVS_W-1:0] dvs;
  logic [ots_pkg::DIV_W-1:0] dvd;
  logic [ots_pkg::DVS_W:0]   trial;
  logic                      ge;

  assign trial = {rem, dvd[ots_pkg::DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(ots_pkg::DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= ge ? ots_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[ots_pkg::DVS_W-1:0];
      dvd <= {dvd[ots_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// File: design/ots_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_window
// Builds the Hann window table for the current hop from the cosine ROM and
// serves it through a registered read port.
// ----------------------------------------------------------------------------
module ots_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        build_start,
  input  logic [ots_pkg::HOP_W-1:0]   hop,
  output logic                        build_busy,
  output ots_pkg::div_req_t           div_req,
  input  ots_pkg::div_rsp_t           div_rsp,
  input  logic [ots_pkg::WIN_AW-1:0]  raddr,
  output logic [ots_pkg::WGT_W-1:0]   rdata
);

  localparam ots_pkg::cos_rom_t COS_ROM = ots_pkg::cos_rom_build();
  localparam int KW = $clog2(ots_pkg::COS_DEPTH + 1);
  localparam int SW = ots_pkg::HOP_W + 1;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_DIV    = 6'b000010,
    B_WAIT   = 6'b000100,
    B_ROM    = 6'b001000,
    B_INTERP = 6'b010000,
    B_SQ     = 6'b100000
  } bstate_t;

  bstate_t                   state;
  logic [ots_pkg::HOP_W-1:0] hop_q;
  logic [ots_pkg::WIN_AW-1:0] i;
  logic [KW-1:0]             k;
  logic [15:0]               f;
  logic [16:0]               c;
  logic [16:0]               diff;
  logic                      falling;
  logic                      at_end;
  logic [16:0]               c_int;
  logic [ots_pkg::WGT_W-1:0] win_mem [0:ots_pkg::WIN_DEPTH-1];

  logic [SW-1:0]             span;
  logic [SW-1:0]             twice_i;
  logic [SW-1:0]             d;
  logic [KW-1:0]             k_raw;
  logic [KW-1:0]             k1;
  logic [32:0]               adj_prod;
  logic [16:0]               adj;
  logic [33:0]               sq;

  assign span    = {hop_q, 1'b0} - SW'(1);
  assign twice_i = {i, 1'b0};
  assign d       = (twice_i > span) ? (twice_i - span) : (span - twice_i);
  assign k_raw   = div_rsp.quotient[16 +: KW];
  assign k1      = (k == KW'(ots_pkg::COS_DEPTH)) ? k : (k + 1'b1);
  assign adj_prod = diff * f + 33'd32768;
  assign adj     = adj_prod[32:16];
  assign sq      = c_int * c_int + 34'd16384;

  assign div_req.start    = (state == B_DIV);
  assign div_req.dividend = ots_pkg::DIV_W'(d) << (ots_pkg::COS_LOG + 16);
  assign div_req.divisor  = ots_pkg::DVS_W'(span);
  assign build_busy       = (state != B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE:   if (build_start) state <= B_DIV;
        B_DIV:    state <= B_WAIT;
        B_WAIT:   if (div_rsp.done) state <= B_ROM;
        B_ROM:    state <= B_INTERP;
        B_INTERP: state <= B_SQ;
        B_SQ:     state <= (SW'(i) == span) ? B_IDLE : B_DIV;
        default:  state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        hop_q <= hop;
        i     <= '0;
      end
      B_WAIT: begin
        k <= (k_raw > KW'(ots_pkg::COS_DEPTH)) ? KW'(ots_pkg::COS_DEPTH) : k_raw;
        f <= div_rsp.quotient[15:0];
      end
      B_ROM: begin
        // cosine falls along the table; pick the sign of the step anyway
        c       <= COS_ROM[k];
        falling <= (COS_ROM[k] >= COS_ROM[k1]);
        diff    <= (COS_ROM[k] >= COS_ROM[k1]) ? (COS_ROM[k] - COS_ROM[k1])
                                                : (COS_ROM[k1] - COS_ROM[k]);
        at_end  <= (k == KW'(ots_pkg::COS_DEPTH));
      end
      B_INTERP: begin
        if (at_end) c_int <= c;
        else if (falling) c_int <= c - adj;
        else c_int <= c + adj;
      end
      B_SQ: begin
        win_mem[i] <= sq[30:15];
        i          <= i + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= win_mem[raddr];
  end

endmodule

// File: design/overlap_add_time_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_add_time_stretch
// Overlap-add time stretch with a Hann window at half overlap.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; command
// selects load sample, load position, run or read output. Loads give no
// result and keep busy low, so one load per cycle goes in while no run or read is under way.
// Run and read give one result: done is high for one cycle with kind,
// status and sample_out; the receiver cannot hold it off.
// A read passes through the 40-step serial divider that normalizes the
// sample by its window-weight sum. An out-of-range read or a run with an
// empty position map answers on the next cycle.
// A run first clears the accumulator, one entry per cycle over all
// MAX_CHANNELS*MAX_OUT_FRAMES entries, while the 2*hop_length-point window
// table is built in parallel; then it walks every hop and frame, passing
// each channel and frame through source read, interpolation, multiply and
// accumulate, bound by the read-modify-write of the accumulator memory.
// Reset restores the register defaults and empties the position map;
// reads before the first run return zero. Configuration writes through
// cfg_write/cfg_index/cfg_data apply at once and saturate to range.
// ----------------------------------------------------------------------------
module overlap_add_time_stretch #(
  parameter int MAX_IN_FRAMES  = 16384,
  parameter int MAX_OUT_FRAMES = 16384,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_HOPS       = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [2:0]                channel,
  input  logic [13:0]               index,
  input  logic signed [15:0]        sample_in,
  input  logic signed [23:0]        position,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [ots_pkg::CFG_W-1:0] cfg_data,
  output logic                      done,
  output logic                      kind,
  output logic                      status,
  output logic signed [15:0]        sample_out
);

  localparam int IN_AW     = $clog2(MAX_IN_FRAMES);
  localparam int OUT_AW    = $clog2(MAX_OUT_FRAMES);
  localparam int SRC_DEPTH = MAX_CHANNELS * MAX_IN_FRAMES;
  localparam int SRC_AW    = $clog2(SRC_DEPTH);
  localparam int ACC_DEPTH = MAX_CHANNELS * MAX_OUT_FRAMES;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int HOP_AW    = $clog2(MAX_HOPS);
  localparam int PC_W      = $clog2(MAX_HOPS + 1);
  localparam int IN_RST    = (16384 > MAX_IN_FRAMES) ? MAX_IN_FRAMES : 16384;
  localparam int OUT_RST   = (16384 > MAX_OUT_FRAMES) ? MAX_OUT_FRAMES : 16384;
  localparam int WA        = ots_pkg::WIN_AW;
  localparam int HW        = ots_pkg::HOP_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLEAR  = 12'b000000000010,
    S_WIN    = 12'b000000000100,
    S_HOP    = 12'b000000001000,
    S_HOP2   = 12'b000000010000,
    S_FRAME  = 12'b000000100000,
    S_SRC    = 12'b000001000000,
    S_INTERP = 12'b000010000000,
    S_MUL    = 12'b000100000000,
    S_ACC    = 12'b001000000000,
    S_RD1    = 12'b010000000000,
    S_RD2    = 12'b100000000000
  } state_t;

  state_t            state;
  logic [HW-1:0]     hop_length;
  logic [3:0]        channel_count;
  logic [14:0]       input_length;
  logic [14:0]       output_length;
  logic              tempo_mode;
  logic [20:0]       tempo_ratio;
  logic [PC_W-1:0]   pos_count;
  logic              mix_valid;

  // sequencer datapath
  logic [ACC_AW-1:0]        clr_addr;
  logic [14:0]              h;
  logic [15:0]              center;
  logic [36:0]              tprod;
  logic signed [31:0]       sp_base;
  logic signed [17:0]       o_base;
  logic [WA-1:0]            i;
  logic [2:0]               ch;
  logic [OUT_AW-1:0]        o_cur;
  logic [IN_AW-1:0]         i0;
  logic [IN_AW-1:0]         i1;
  logic [7:0]               frac;
  logic signed [15:0]       interp;
  logic signed [32:0]       prod;
  logic                     rd_neg;

  // memories and their read registers
  logic signed [15:0] src_mem [0:SRC_DEPTH-1];
  logic signed [23:0] pos_mem [0:MAX_HOPS-1];
  logic signed [31:0] acc_mem [0:ACC_DEPTH-1];
  logic [17:0]        wsum_mem [0:MAX_OUT_FRAMES-1];
  logic signed [15:0] src_q0;
  logic signed [15:0] src_q1;
  logic signed [23:0] pos_q;
  logic signed [31:0] acc_q;
  logic [17:0]        wsum_q;

  logic                      take;
  logic                      win_start;
  logic                      win_busy;
  logic [ots_pkg::WGT_W-1:0] win_w;
  ots_pkg::div_req_t         win_div_req;
  ots_pkg::div_req_t         rd_div_req;
  ots_pkg::div_req_t         div_req;
  ots_pkg::div_rsp_t         div_rsp;

  logic                src_we;
  logic [SRC_AW-1:0]   src_waddr;
  logic                pos_we;
  logic                acc_we;
  logic [ACC_AW-1:0]   acc_waddr;
  logic signed [31:0]  acc_wdata;
  logic                acc_re;
  logic [ACC_AW-1:0]   acc_raddr;
  logic                wsum_we;
  logic [OUT_AW-1:0]   wsum_waddr;
  logic [17:0]         wsum_wdata;
  logic                wsum_re;
  logic [OUT_AW-1:0]   wsum_raddr;
  logic [ACC_AW-1:0]   acc_addr;

  logic                read_bad;
  logic                run_empty;
  logic [HW:0]         win_last;
  logic                i_last;
  logic                ch_last;
  logic                hop_stop;
  logic [36:0]         tsum;
  logic signed [31:0]  pos_val;
  logic signed [17:0]  o_sig;
  logic                o_skip;
  logic signed [31:0]  sp;
  logic signed [31:0]  sp_last;
  logic [IN_AW-1:0]    in_last;
  logic [8:0]          fw;
  logic signed [26:0]  p0;
  logic signed [26:0]  p1;
  logic signed [26:0]  v;
  logic signed [33:0]  tsat;
  logic signed [31:0]  acc_new;
  logic signed [31:0]  a_eff;
  logic [31:0]         mag;
  logic [17:0]         n_div;
  logic [ots_pkg::DIV_W-1:0] qm;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;

  assign read_bad  = (32'(channel) >= 32'(channel_count)) ||
                     (32'(index) >= 32'(output_length));
  assign run_empty = !tempo_mode && (pos_count == '0);
  assign win_start = take && (command == ots_pkg::CMD_RUN) && !run_empty;

  assign win_last = {hop_length, 1'b0} - (HW + 1)'(1);
  assign i_last   = ((HW + 1)'(i) == win_last);
  assign ch_last  = ({1'b0, ch} == (channel_count - 4'd1));
  assign hop_stop = (!tempo_mode && (32'(h) >= 32'(pos_count))) ||
                    (32'(center) >= 32'(output_length));

  assign tsum    = tprod + 37'd128;
  assign pos_val = tempo_mode ? $signed({3'b000, tsum[36:8]}) : 32'(pos_q);

  assign o_sig   = o_base + $signed({{(18 - WA){1'b0}}, i});
  assign o_skip  = o_sig[17] || (o_sig[16:0] >= {2'b00, output_length});
  assign sp      = sp_base + $signed({{(24 - WA){1'b0}}, i, 8'b0});
  assign sp_last = $signed({9'b0, input_length - 15'd1, 8'b0});
  assign in_last = IN_AW'(input_length - 15'd1);

  assign acc_addr = ACC_AW'(32'(ch) * MAX_OUT_FRAMES + 32'(o_cur));

  // linear interpolation between neighboring source frames, floor after +half
  assign fw = 9'd256 - {1'b0, frac};
  assign p0 = src_q0 * $signed({1'b0, fw});
  assign p1 = src_q1 * $signed({1'b0, frac});
  assign v  = p0 + p1 + 27'sd128;

  assign tsat = acc_q + prod;
  always_comb begin
    if (!tsat[33] && (tsat[32:31] != 2'b00)) acc_new = 32'sh7FFF_FFFF;
    else if (tsat[33] && (tsat[32:31] != 2'b11)) acc_new = 32'sh8000_0000;
    else acc_new = tsat[31:0];
  end

  assign a_eff = mix_valid ? acc_q : 32'sd0;
  assign mag   = a_eff[31] ? (~a_eff + 32'd1) : a_eff;
  assign n_div = (mix_valid && (wsum_q != '0)) ? wsum_q : 18'd32768;
  assign qm    = div_rsp.quotient;

  assign rd_div_req.start    = (state == S_RD1);
  assign rd_div_req.dividend = ots_pkg::DIV_W'(mag) + ots_pkg::DIV_W'(n_div[17:1]);
  assign rd_div_req.divisor  = n_div;
  assign div_req = (state == S_RD1) ? rd_div_req : win_div_req;

  // memory port selection
  always_comb begin
    src_we     = take && (command == ots_pkg::CMD_LOAD_SAMPLE) &&
                 (32'(channel) < MAX_CHANNELS) && (32'(index) < MAX_IN_FRAMES);
    src_waddr  = SRC_AW'(32'(channel) * MAX_IN_FRAMES + 32'(index));
    pos_we     = take && (command == ots_pkg::CMD_LOAD_POSITION) &&
                 (32'(index) < MAX_HOPS);
    acc_we     = 1'b0;
    acc_waddr  = acc_addr;
    acc_wdata  = acc_new;
    acc_re     = 1'b0;
    acc_raddr  = acc_addr;
    wsum_we    = 1'b0;
    wsum_waddr = o_cur;
    wsum_wdata = wsum_q + 18'(win_w);
    wsum_re    = 1'b0;
    wsum_raddr = o_cur;
    case (state)
      S_IDLE: begin
        if (take && (command == ots_pkg::CMD_READ)) begin
          acc_re     = 1'b1;
          acc_raddr  = ACC_AW'(32'(channel) * MAX_OUT_FRAMES + 32'(index));
          wsum_re    = 1'b1;
          wsum_raddr = OUT_AW'(index);
        end
      end
      S_CLEAR: begin
        acc_we     = 1'b1;
        acc_waddr  = clr_addr;
        acc_wdata  = 32'sd0;
        wsum_we    = (32'(clr_addr) < MAX_OUT_FRAMES);
        wsum_waddr = OUT_AW'(clr_addr);
        wsum_wdata = '0;
      end
      S_SRC: begin
        acc_re  = 1'b1;
        wsum_re = 1'b1;
      end
      S_ACC: begin
        acc_we  = 1'b1;
        wsum_we = (ch == 3'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= sample_in;
    if (state == S_SRC) begin
      src_q0 <= src_mem[SRC_AW'(32'(ch) * MAX_IN_FRAMES + 32'(i0))];
      src_q1 <= src_mem[SRC_AW'(32'(ch) * MAX_IN_FRAMES + 32'(i1))];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[HOP_AW'(index)] <= position;
    if (state == S_HOP) pos_q <= pos_mem[HOP_AW'(h)];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (wsum_we) wsum_mem[wsum_waddr] <= wsum_wdata;
    if (wsum_re) wsum_q <= wsum_mem[wsum_raddr];
  end

  // control, configuration and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hop_length    <= HW'(512);
      channel_count <= 4'd1;
      input_length  <= 15'(IN_RST);
      output_length <= 15'(OUT_RST);
      tempo_mode    <= 1'b0;
      tempo_ratio   <= 21'(65536);
      pos_count     <= '0;
      mix_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (ots_pkg::reg_t'(cfg_index))
          ots_pkg::REG_HOP: begin
            if (cfg_data[HW-1:0] < HW'(ots_pkg::HOP_MIN)) hop_length <= HW'(ots_pkg::HOP_MIN);
            else if (cfg_data[HW-1:0] > HW'(ots_pkg::HOP_MAX)) hop_length <= HW'(ots_pkg::HOP_MAX);
            else hop_length <= cfg_data[HW-1:0];
          end
          ots_pkg::REG_CHANNELS: begin
            if (cfg_data[3:0] == 4'd0) channel_count <= 4'd1;
            else if (32'(cfg_data[3:0]) > MAX_CHANNELS) channel_count <= 4'(MAX_CHANNELS);
            else channel_count <= cfg_data[3:0];
          end
          ots_pkg::REG_IN_LEN: begin
            if (cfg_data[14:0] == 15'd0) input_length <= 15'd1;
            else if (32'(cfg_data[14:0]) > MAX_IN_FRAMES) input_length <= 15'(MAX_IN_FRAMES);
            else input_length <= cfg_data[14:0];
          end
          ots_pkg::REG_OUT_LEN: begin
            if (cfg_data[14:0] == 15'd0) output_length <= 15'd1;
            else if (32'(cfg_data[14:0]) > MAX_OUT_FRAMES) output_length <= 15'(MAX_OUT_FRAMES);
            else output_length <= cfg_data[14:0];
          end
          ots_pkg::REG_TEMPO_MODE: tempo_mode <= cfg_data[0];
          ots_pkg::REG_TEMPO: begin
            if (32'(cfg_data) < ots_pkg::TEMPO_MIN) tempo_ratio <= 21'(ots_pkg::TEMPO_MIN);
            else if (32'(cfg_data) > ots_pkg::TEMPO_MAX) tempo_ratio <= 21'(ots_pkg::TEMPO_MAX);
            else tempo_ratio <= cfg_data;
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            case (ots_pkg::cmd_t'(command))
              ots_pkg::CMD_LOAD_POSITION: begin
                if (pos_we && (32'(index) + 32'd1 > 32'(pos_count)))
                  pos_count <= PC_W'(32'(index) + 32'd1);
              end
              ots_pkg::CMD_RUN: begin
                if (run_empty) begin
                  done       <= 1'b1;
                  kind       <= ots_pkg::KIND_RUN;
                  status     <= ots_pkg::ST_EMPTY;
                  sample_out <= '0;
                end else begin
                  state <= S_CLEAR;
                end
              end
              ots_pkg::CMD_READ: begin
                if (read_bad) begin
                  done       <= 1'b1;
                  kind       <= ots_pkg::KIND_READ;
                  status     <= ots_pkg::ST_OK;
                  sample_out <= '0;
                end else begin
                  state <= S_RD1;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_addr == ACC_AW'(ACC_DEPTH - 1)) begin
            state     <= S_WIN;
            mix_valid <= 1'b1;
          end
        end
        S_WIN: if (!win_busy) state <= S_HOP;
        S_HOP: begin
          if (hop_stop) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            kind       <= ots_pkg::KIND_RUN;
            status     <= ots_pkg::ST_OK;
            sample_out <= '0;
          end else begin
            state <= S_HOP2;
          end
        end
        S_HOP2: state <= S_FRAME;
        S_FRAME: begin
          if (!o_skip) state <= S_SRC;
          else if (i_last) state <= S_HOP;
        end
        S_SRC:    state <= S_INTERP;
        S_INTERP: state <= S_MUL;
        S_MUL:    state <= S_ACC;
        S_ACC: begin
          if (!ch_last) state <= S_SRC;
          else if (i_last) state <= S_HOP;
          else state <= S_FRAME;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          if (div_rsp.done) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            kind   <= ots_pkg::KIND_READ;
            status <= ots_pkg::ST_OK;
            if (rd_neg)
              sample_out <= (qm > ots_pkg::DIV_W'(32768)) ? 16'sh8000 : 16'(~qm[15:0] + 16'd1);
            else
              sample_out <= (qm > ots_pkg::DIV_W'(32767)) ? 16'sh7FFF : qm[15:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        clr_addr <= '0;
        h        <= '0;
        center   <= '0;
      end
      S_CLEAR: clr_addr <= clr_addr + 1'b1;
      S_HOP: tprod <= center * tempo_ratio;
      S_HOP2: begin
        sp_base <= pos_val - $signed({11'b0, hop_length, 8'b0});
        o_base  <= $signed({2'b00, center}) - $signed({5'b0, hop_length});
        i       <= '0;
      end
      S_FRAME: begin
        o_cur <= OUT_AW'(o_sig[16:0]);
        ch    <= 3'd0;
        // clamp reads at the clip ends
        if (sp[31] || (sp == 32'sd0)) begin
          i0   <= '0;
          i1   <= '0;
          frac <= '0;
        end else if (sp >= sp_last) begin
          i0   <= in_last;
          i1   <= in_last;
          frac <= '0;
        end else begin
          i0   <= sp[IN_AW+7:8];
          i1   <= sp[IN_AW+7:8] + 1'b1;
          frac <= sp[7:0];
        end
        if (o_skip) begin
          if (i_last) begin
            h      <= h + 1'b1;
            center <= center + 16'(hop_length);
          end else begin
            i <= i + 1'b1;
          end
        end
      end
      S_INTERP: interp <= 16'(v >>> 8);
      S_MUL: prod <= interp * $signed({1'b0, win_w});
      S_ACC: begin
        if (!ch_last) begin
          ch <= ch + 1'b1;
        end else if (i_last) begin
          h      <= h + 1'b1;
          center <= center + 16'(hop_length);
        end else begin
          i <= i + 1'b1;
        end
      end
      S_RD1: rd_neg <= a_eff[31];
      default: ;
    endcase
  end

  ots_window u_window (
    .clk         (clk),
    .rst         (rst),
    .build_start (win_start),
    .hop         (hop_length),
    .build_busy  (win_busy),
    .div_req     (win_div_req),
    .div_rsp     (div_rsp),
    .raddr       (i),
    .rdata       (win_w)
  );

  ots_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_empty_map: assert property (@(posedge clk) disable iff (rst)
    (take && (command == ots_pkg::CMD_RUN) && !tempo_mode && (pos_count == '0))
      |=> (done && (kind == ots_pkg::KIND_RUN) && (status == ots_pkg::ST_EMPTY)))
    else $error("empty map run did not report");
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (kind == ots_pkg::KIND_READ)) |-> (status == ots_pkg::ST_OK))
    else $error("read result with bad status");
  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (kind == ots_pkg::KIND_RUN)) |-> (sample_out == 16'sd0))
    else $error("run result carries sample data");
`endif

endmodule

// File: dv/tb_overlap_add_time_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overlap_add_time_stretch
// Self-checking bench for the overlap-add time stretch block.
// ----------------------------------------------------------------------------
// Requests are queued by phase: source and position loads, a run, then a
// random mix of reads and loads. A local model of the stretch predicts every
// run status and read sample; the monitor checks each result against the
// oldest prediction. Registers change only between phases, with the block
// idle, and sweep their saturation extremes.
// ----------------------------------------------------------------------------
module tb_overlap_add_time_stretch;
  import ots_pkg::*;

  localparam int IN_FRAMES   = 16384;
  localparam int OUT_FRAMES  = 16384;
  localparam int CHANS       = 8;
  localparam int HOPS        = 512;
  localparam int QUIET_LIMIT = 2000000;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef struct {
    cmd_t               cmd;
    logic [2:0]         ch;
    logic [13:0]        idx;
    logic signed [15:0] smp;
    logic signed [23:0] pos;
  } request_t;

  typedef struct {
    logic               kind;
    logic               status;
    logic signed [15:0] smp;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = CMD_LOAD_SAMPLE;
  logic [2:0] channel = '0;
  logic [13:0] index = '0;
  logic signed [15:0] sample_in = '0;
  logic signed [23:0] position = '0;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic kind;
  logic status;
  logic signed [15:0] sample_out;

  overlap_add_time_stretch dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .channel(channel), .index(index), .sample_in(sample_in),
    .position(position), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .kind(kind), .status(status),
    .sample_out(sample_out)
  );

  always #2 clk = ~clk;

  // stretch model state
  int unsigned cos_q15 [0:256];
  int unsigned win_tab [0:2*HOP_MAX-1];
  logic signed [15:0] src_mem [0:CHANS*IN_FRAMES-1];
  logic signed [23:0] pos_mem [0:HOPS-1];
  int mix_acc [0:CHANS*OUT_FRAMES-1];
  int unsigned wsum [0:OUT_FRAMES-1];
  int unsigned pos_cnt;
  int unsigned m_hop, m_chans, m_in_len, m_out_len, m_tempo_mode, m_tempo;

  request_t req_q[$];
  result_t  result_q[$];
  int errors = 0;
  int n_requests = 0;
  int n_runs = 0;
  int n_reads = 0;
  int gen_pos_cnt = 0;
  bit taken = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned quarter_cos(int unsigned k);
    longint unsigned x, x2, term, r;
    longint acc;
    x = 64'd1686629713 * k / 256;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    acc = longint'(term);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (longint'(acc) + 16384) >> 15;
    return (r > 32768) ? 32768 : int'(r);
  endfunction

  function automatic int unsigned hann_weight(int unsigned i, int unsigned win);
    longint unsigned span, d, t, k, f, c, c1;
    span = win - 1;
    d = (2 * i > span) ? 2 * i - span : span - 2 * i;
    t = d * 256;
    k = t / span;
    f = ((t % span) << 16) / span;
    if (k > 256) k = 256;
    c = cos_q15[k];
    if (k < 256) begin
      c1 = cos_q15[k + 1];
      if (c >= c1) c = c - (((c - c1) * f + 32768) >> 16);
      else c = c + (((c1 - c) * f + 32768) >> 16);
    end
    return int'((c * c + 16384) >> 15);
  endfunction

  function automatic longint source_at(int unsigned ch, longint sp);
    int unsigned base;
    longint i0, fr, v;
    base = ch * IN_FRAMES;
    if (sp <= 0) return src_mem[base];
    if (sp >= longint'(m_in_len - 1) * 256) return src_mem[base + m_in_len - 1];
    i0 = sp >>> 8;
    fr = sp & 255;
    v = longint'(src_mem[base + i0]) * (256 - fr) + longint'(src_mem[base + i0 + 1]) * fr;
    return (v + 128) >>> 8;
  endfunction

  function automatic logic stretch(); 
    longint center, pos, o, sp, t;
    int unsigned w;
    if (!m_tempo_mode && pos_cnt == 0) return ST_EMPTY;
    for (int i = 0; i < 2 * m_hop; i++) win_tab[i] = hann_weight(i, 2 * m_hop);
    for (int i = 0; i < CHANS * OUT_FRAMES; i++) mix_acc[i] = 0;
    for (int i = 0; i < OUT_FRAMES; i++) wsum[i] = 0;
    for (int h = 0; ; h++) begin
      center = longint'(h) * m_hop;
      if (!m_tempo_mode && h >= pos_cnt) break;
      if (center >= m_out_len) break;
      if (m_tempo_mode) pos = (center * m_tempo + 128) >> 8;
      else pos = pos_mem[h];
      for (int i = 0; i < 2 * m_hop; i++) begin
        o = center - m_hop + i;
        sp = pos - longint'(m_hop) * 256 + longint'(i) * 256;
        w = win_tab[i];
        if (o < 0 || o >= m_out_len) continue;
        for (int ch = 0; ch < m_chans; ch++) begin
          t = longint'(mix_acc[ch * OUT_FRAMES + o]) + source_at(ch, sp) * w;
          if (t > 64'sd2147483647) t = 64'sd2147483647;
          if (t < -64'sd2147483648) t = -64'sd2147483648;
          mix_acc[ch * OUT_FRAMES + o] = int'(t);
        end
        wsum[o] += w;
      end
    end
    return ST_OK;
  endfunction

  function automatic logic signed [15:0] normalized(int unsigned ch, int unsigned idx);
    longint a, n, mag, q;
    if (ch >= m_chans || idx >= m_out_len) return '0;
    a = mix_acc[ch * OUT_FRAMES + idx];
    n = (wsum[idx] == 0) ? 32768 : wsum[idx];
    mag = (a < 0) ? -a : a;
    q = (mag + n / 2) / n;
    if (a < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic apply_request(request_t r);
    result_t e;
    case (r.cmd)
      CMD_LOAD_SAMPLE: src_mem[r.ch * IN_FRAMES + r.idx] = r.smp;
      CMD_LOAD_POSITION: begin
        if (r.idx < HOPS) begin
          pos_mem[r.idx] = r.pos;
          if (r.idx + 1 > pos_cnt) pos_cnt = r.idx + 1;
        end
      end
      CMD_RUN: begin
        e = '{KIND_RUN, stretch(), '0};
        result_q.push_back(e);
        n_runs++;
      end
      default: begin
        e = '{KIND_READ, ST_OK, normalized(r.ch, r.idx)};
        result_q.push_back(e);
        n_reads++;
      end
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: bursts of requests separated by random gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    if (taken) begin
      void'(req_q.pop_front());
      taken = 0;
    end
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (req_q.size() > 0) begin
      start <= 1'b1;
      command <= req_q[0].cmd;
      channel <= req_q[0].ch;
      index <= req_q[0].idx;
      sample_in <= req_q[0].smp;
      position <= req_q[0].pos;
      if (--burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and watchdog
  int quiet = 0;
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (start && !busy) begin
        apply_request(req_q[0]);
        n_requests++;
        taken = 1;
      end
      if (done) begin
        if (result_q.size() == 0) begin
          report("unexpected result kind", kind, -1);
        end else begin
          e = result_q.pop_front();
          if (kind !== e.kind) report("kind", kind, e.kind);
          if (status !== e.status) report("status", status, e.status);
          if (sample_out !== e.smp) report("sample_out", sample_out, e.smp);
        end
      end
      quiet = ((start && !busy) || done) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push(cmd_t c, int ch, int idx, int smp, int pos);
    request_t r;
    r.cmd = c;
    r.ch = ch[2:0];
    r.idx = idx[13:0];
    r.smp = smp[15:0];
    r.pos = pos[23:0];
    req_q.push_back(r);
  endtask

  task automatic write_reg(logic [2:0] sel, int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    case (sel)
      REG_HOP:        m_hop = clamp(value & 32'h1FFF, HOP_MIN, HOP_MAX);
      REG_CHANNELS:   m_chans = clamp(value & 32'hF, 1, CHANS);
      REG_IN_LEN:     m_in_len = clamp(value & 32'h7FFF, 1, IN_FRAMES);
      REG_OUT_LEN:    m_out_len = clamp(value & 32'h7FFF, 1, OUT_FRAMES);
      REG_TEMPO_MODE: m_tempo_mode = value & 1;
      REG_TEMPO:      m_tempo = clamp(value & 32'h1FFFFF, TEMPO_MIN, TEMPO_MAX);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || result_q.size() > 0) @(posedge clk);
    // loads give no result, let the last one settle
    repeat (60) @(posedge clk);
  endtask

  task automatic load_source(int frames);
    for (int ch = 0; ch < m_chans; ch++)
      for (int f = 0; f < frames; f++)
        push(CMD_LOAD_SAMPLE, ch, f, $urandom, 0);
  endtask

  task automatic add_random(int count);
    int sel, ch, idx;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, m_chans - 1);
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                          : $urandom_range(0, m_out_len + 2);
        push(CMD_READ, ch, idx, $urandom, $urandom);
      end else if (sel < 85) begin
        push(CMD_LOAD_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 16383), $urandom, 0);
      end else begin
        // stay inside the written map or past its end
        idx = (gen_pos_cnt == 0 || $urandom_range(0, 1)) ? $urandom_range(HOPS, 16383)
                                                         : $urandom_range(0, gen_pos_cnt - 1);
        push(CMD_LOAD_POSITION, $urandom, idx, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int k = 0; k <= 256; k++) cos_q15[k] = quarter_cos(k);
    for (int i = 0; i < CHANS * IN_FRAMES; i++) src_mem[i] = '0;
    for (int i = 0; i < HOPS; i++) pos_mem[i] = '0;
    for (int i = 0; i < CHANS * OUT_FRAMES; i++) mix_acc[i] = 0;
    for (int i = 0; i < OUT_FRAMES; i++) wsum[i] = 0;
    pos_cnt = 0;
    m_hop = 512;
    m_chans = 1;
    m_in_len = 16384;
    m_out_len = 16384;
    m_tempo_mode = 0;
    m_tempo = 65536;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: empty map, reads before any run, out-of-range requests
    push(CMD_READ, 0, 0, 0, 0);
    push(CMD_READ, 0, 16383, 0, 0);
    push(CMD_READ, 1, 0, 0, 0);
    push(CMD_RUN, 0, 0, 0, 0);
    push(CMD_LOAD_POSITION, 0, 600, 0, 123);
    push(CMD_RUN, 0, 0, 0, 0);
    push(CMD_LOAD_SAMPLE, 7, 16383, -32768, 0);
    push(CMD_LOAD_SAMPLE, 7, 16382, 32767, 0);
    push(CMD_READ, 7, 16383, 0, 0);
    drain();

    // map mode, two channels, positions at both extremes
    write_reg(REG_HOP, 0);
    write_reg(REG_CHANNELS, 2);
    write_reg(REG_IN_LEN, 300);
    write_reg(REG_OUT_LEN, 400);
    write_reg(REG_TEMPO_MODE, 0);
    write_reg(REG_TEMPO, 0);
    write_reg(REG_SPARE, 77);
    load_source(300);
    push(CMD_LOAD_SAMPLE, 0, 0, -32768, 0);
    push(CMD_LOAD_SAMPLE, 1, 299, 32767, 0);
    push(CMD_LOAD_POSITION, 0, 0, 0, -8388608);
    push(CMD_LOAD_POSITION, 0, 1, 0, 8388607);
    for (int h = 2; h < 10; h++)
      push(CMD_LOAD_POSITION, 0, h, 0, int'($urandom_range(0, 420 * 256)) - 40 * 256);
    gen_pos_cnt = 10;
    push(CMD_RUN, 0, 0, 0, 0);
    add_random(250);
    drain();

    // tempo mode, slowest tempo, eight channels, one-frame source
    write_reg(REG_TEMPO_MODE, 1);
    write_reg(REG_TEMPO, 0);
    write_reg(REG_HOP, 100);
    write_reg(REG_CHANNELS, 15);
    write_reg(REG_IN_LEN, 0);
    write_reg(REG_OUT_LEN, 500);
    load_source(1);
    push(CMD_RUN, 0, 0, 0, 0);
    add_random(250);
    drain();

    // longest hop, fastest tempo, full-length source
    write_reg(REG_TEMPO, 21'h1FFFFF);
    write_reg(REG_HOP, 8191);
    write_reg(REG_CHANNELS, 0);
    write_reg(REG_IN_LEN, 15'h7FFF);
    write_reg(REG_OUT_LEN, 3000);
    load_source(4098);
    push(CMD_RUN, 0, 0, 0, 0);
    add_random(150);
    drain();

    // one output frame
    write_reg(REG_HOP, 64);
    write_reg(REG_TEMPO, 65536);
    write_reg(REG_CHANNELS, 3);
    write_reg(REG_IN_LEN, 200);
    write_reg(REG_OUT_LEN, 0);
    load_source(200);
    push(CMD_RUN, 0, 0, 0, 0);
    add_random(100);
    drain();

    while (result_q.size() > 0) begin
      report("missing result kind", -1, result_q[0].kind);
      void'(result_q.pop_front());
    end
    $display("covered %0d requests: %0d runs and %0d reads over five register settings",
             n_requests, n_runs, n_reads);
    $display("mismatches: %0d", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
